// File: design/ttb_pkg.sv
package ttb_pkg;

  // Fixed widths of the datapath
  localparam int unsigned IdxW  = 16;
  localparam int unsigned PosW  = 32;
  localparam int unsigned TexW  = 16;
  localparam int unsigned DpW   = PosW + 1;     // position delta, Q17.16
  localparam int unsigned DuvW  = TexW + 1;     // texcoord delta, Q5.12
  localparam int unsigned ProdW = DpW + DuvW;   // one product
  localparam int unsigned NumW  = ProdW + 1;    // numerator or determinant
  localparam int unsigned DetW  = 2 * DuvW + 1; // UV determinant
  localparam int unsigned ResW  = 32;
  localparam int unsigned FracShift = 12;       // Q4.12 to Q16.16 scale
  localparam int unsigned InDataW  = 144;
  localparam int unsigned OutDataW = 240;

  // One closed triangle, handed from the front to the back
  typedef struct packed {
    logic [IdxW-1:0] idx_a;
    logic [IdxW-1:0] idx_b;
    logic [IdxW-1:0] idx_c;
    logic [2:0][DpW-1:0] dp1;
    logic [2:0][DpW-1:0] dp2;
    logic [DuvW-1:0] du1;
    logic [DuvW-1:0] dv1;
    logic [DuvW-1:0] du2;
    logic [DuvW-1:0] dv2;
  } tri_t;

endpackage

// File: design/ttb_front.sv
module ttb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        idx_i,
  input  logic [2:0][31:0]   pos_i,
  input  logic [1:0][15:0]   tex_i,
  output logic               push_o,
  input  logic               push_ready_i,
  output ttb_pkg::tri_t      push_data_o
);

  logic [1:0]        cnt_q, cnt_d;
  logic [1:0][15:0]  idx_q;
  logic [1:0][2:0][31:0] pos_q;
  logic [1:0][1:0][15:0] tex_q;
  logic              third;
  logic              take;

  assign third      = (cnt_q == 2'd2);
  assign in_ready_o = !third || push_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign push_o     = take && third;

  // Count corners of the open triangle
  always_comb begin
    cnt_d = cnt_q;
    if (take) begin
      cnt_d = third ? 2'd0 : cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold the first two corners
  always_ff @(posedge clk_i) begin
    if (take && !third) begin
      idx_q[cnt_q[0]] <= idx_i;
      pos_q[cnt_q[0]] <= pos_i;
      tex_q[cnt_q[0]] <= tex_i;
    end
  end

  // Form edge deltas on the closing corner
  always_comb begin
    push_data_o       = '0;
    push_data_o.idx_a = idx_q[0];
    push_data_o.idx_b = idx_q[1];
    push_data_o.idx_c = idx_i;
    for (int k = 0; k < 3; k++) begin
      push_data_o.dp1[k] = {pos_q[1][k][31], pos_q[1][k]} - {pos_q[0][k][31], pos_q[0][k]};
      push_data_o.dp2[k] = {pos_i[k][31], pos_i[k]} - {pos_q[0][k][31], pos_q[0][k]};
    end
    push_data_o.du1 = {tex_q[1][0][15], tex_q[1][0]} - {tex_q[0][0][15], tex_q[0][0]};
    push_data_o.dv1 = {tex_q[1][1][15], tex_q[1][1]} - {tex_q[0][1][15], tex_q[0][1]};
    push_data_o.du2 = {tex_i[0][15], tex_i[0]} - {tex_q[0][0][15], tex_q[0][0]};
    push_data_o.dv2 = {tex_i[1][15], tex_i[1]} - {tex_q[0][1][15], tex_q[0][1]};
  end

endmodule

// File: design/ttb_fifo.sv
module ttb_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          push_ready_o,
  input  ttb_pkg::tri_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output ttb_pkg::tri_t pop_data_o
);

  ttb_pkg::tri_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: design/ttb_div.sv
module ttb_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ttb_pkg::NumW-1:0]   num_i,
  input  logic [ttb_pkg::DetW-1:0]   det_i,
  output logic                       done_o,
  output logic [ttb_pkg::ResW-1:0]   res_o
);

  typedef enum logic [1:0] {V_IDLE, V_CHK, V_RUN, V_DONE} div_state_e;

  div_state_e  state_q;
  logic        neg_q;
  logic [61:0] n_q;
  logic [33:0] d_q;
  logic [33:0] r_q;
  logic [31:0] q_q;
  logic [4:0]  cnt_q;
  logic [ttb_pkg::NumW-1:0] abs_n;
  logic [ttb_pkg::DetW-1:0] abs_d;
  logic [34:0] r2;
  logic        fit;

  assign abs_n = num_i[ttb_pkg::NumW-1] ? -num_i : num_i;
  assign abs_d = det_i[ttb_pkg::DetW-1] ? -det_i : det_i;
  assign r2    = {r_q, n_q[31]};
  assign fit   = (r2 >= {1'b0, d_q});

  // Restoring division, one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= V_IDLE;
      cnt_q   <= 5'd0;
    end else begin
      case (state_q)
        V_IDLE: begin
          if (start_i) begin
            neg_q   <= num_i[ttb_pkg::NumW-1] ^ det_i[ttb_pkg::DetW-1];
            n_q     <= {abs_n[49:0], 12'b0};
            d_q     <= abs_d[33:0];
            state_q <= V_CHK;
          end
        end
        V_CHK: begin
          // quotient of 2^32 or more saturates either way
          if ({4'b0, n_q[61:32]} >= d_q) begin
            q_q     <= '1;
            state_q <= V_DONE;
          end else begin
            r_q     <= {4'b0, n_q[61:32]};
            cnt_q   <= 5'd0;
            state_q <= V_RUN;
          end
        end
        V_RUN: begin
          if (fit) begin
            r_q <= 34'(r2 - {1'b0, d_q});
          end else begin
            r_q <= r2[33:0];
          end
          q_q   <= {q_q[30:0], fit};
          n_q   <= {n_q[60:0], 1'b0};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= V_DONE;
          end
        end
        V_DONE: begin
          state_q <= V_IDLE;
        end
        default: begin
          state_q <= V_IDLE;
        end
      endcase
    end
  end

  assign done_o = (state_q == V_DONE);

  // Apply sign and saturate
  always_comb begin
    if (neg_q) begin
      res_o = (q_q > 32'h8000_0000) ? 32'h8000_0000 : -q_q;
    end else begin
      res_o = (q_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_q;
    end
  end

endmodule

// File: design/ttb_back.sv
module ttb_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pop_valid_i,
  output logic                            pop_o,
  input  ttb_pkg::tri_t                   pop_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ttb_pkg::OutDataW-1:0]    out_data_o,
  output logic                            out_degen_o
);

  typedef enum logic [2:0] {B_IDLE, B_MUL1, B_MUL2, B_DSTART, B_DWAIT, B_OUT} back_state_e;

  localparam logic [2:0] SelDet  = 3'd0;
  localparam logic [2:0] SelTan  = 3'd1;
  localparam logic [2:0] SelBit  = 3'd4;
  localparam logic [2:0] SelLast = 3'd6;

  back_state_e   state_q;
  logic [2:0]    sel_q;
  ttb_pkg::tri_t tri_q;
  logic signed [ttb_pkg::ProdW-1:0] prod_q;
  logic [ttb_pkg::DetW-1:0] det_q;
  logic [ttb_pkg::NumW-1:0] num_q;
  logic [5:0][31:0] res_q;
  logic          degen_q;
  logic          valid_q;
  logic [ttb_pkg::OutDataW-1:0] data_q;
  logic          udeg_q;

  logic signed [ttb_pkg::DpW-1:0]  ma, mc;
  logic signed [ttb_pkg::DuvW-1:0] mb, md;
  logic signed [ttb_pkg::NumW-1:0] diff;
  logic [1:0]    k;
  logic          div_done;
  logic [31:0]   div_res;
  logic [5:0][31:0] vec;
  logic          out_load;

  // Pick product operands for the term in work
  always_comb begin
    k  = 2'd0;
    ma = $signed({{16{tri_q.du1[16]}}, tri_q.du1});
    mb = $signed(tri_q.dv2);
    mc = $signed({{16{tri_q.dv1[16]}}, tri_q.dv1});
    md = $signed(tri_q.du2);
    if (sel_q >= SelBit) begin
      k  = 2'(sel_q - SelBit);
      ma = $signed(tri_q.dp2[k]);
      mb = $signed(tri_q.du1);
      mc = $signed(tri_q.dp1[k]);
      md = $signed(tri_q.du2);
    end else if (sel_q >= SelTan) begin
      k  = 2'(sel_q - SelTan);
      ma = $signed(tri_q.dp1[k]);
      mb = $signed(tri_q.dv2);
      mc = $signed(tri_q.dp2[k]);
      md = $signed(tri_q.dv1);
    end
  end

  assign diff  = ttb_pkg::NumW'(prod_q) - ttb_pkg::NumW'(mc * md);
  assign pop_o = (state_q == B_IDLE) && pop_valid_i;

  // Load the output register when the result is ready and the slot is free
  assign out_load = (state_q == B_OUT) && (!valid_q || out_ready_i);

  ttb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == B_DSTART),
    .num_i  (num_q),
    .det_i  (det_q),
    .done_o (div_done),
    .res_o  (div_res)
  );

  assign vec = degen_q ? '0 : res_q;

  // Sequence determinant, six numerators and six divisions; a zero determinant skips to the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      sel_q   <= SelDet;
      valid_q <= 1'b0;
    end else begin
      if (valid_q && out_ready_i && !out_load) begin
        valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop_valid_i) begin
            tri_q   <= pop_data_i;
            sel_q   <= SelDet;
            state_q <= B_MUL1;
          end
        end
        B_MUL1: begin
          prod_q  <= ma * mb;
          state_q <= B_MUL2;
        end
        B_MUL2: begin
          if (sel_q == SelDet) begin
            det_q   <= diff[ttb_pkg::DetW-1:0];
            degen_q <= (diff == '0);
            if (diff == '0) begin
              state_q <= B_OUT;
            end else begin
              sel_q   <= SelTan;
              state_q <= B_MUL1;
            end
          end else begin
            num_q   <= diff;
            state_q <= B_DSTART;
          end
        end
        B_DSTART: begin
          state_q <= B_DWAIT;
        end
        B_DWAIT: begin
          if (div_done) begin
            res_q[sel_q - SelTan] <= div_res;
            if (sel_q == SelLast) begin
              state_q <= B_OUT;
            end else begin
              sel_q   <= sel_q + 3'd1;
              state_q <= B_MUL1;
            end
          end
        end
        B_OUT: begin
          if (out_load) begin
            valid_q <= 1'b1;
            data_q  <= {vec[5], vec[4], vec[3], vec[2], vec[1], vec[0],
                        tri_q.idx_c, tri_q.idx_b, tri_q.idx_a};
            udeg_q  <= degen_q;
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_degen_o = udeg_q;

endmodule

// File: design/triangle_tangent_basis.sv
// Tangent and bitangent generator for indexed triangles.
// Slave stream: one triangle corner per beat; tdata carries the vertex index,
// position x/y/z (Q16.16) and texture u/v (Q4.12). Every third beat closes a
// triangle. Master stream: one beat per triangle with the three indices and
// tangent and bitangent (Q16.16, saturated); tuser flags a zero UV
// determinant, in which case both vectors are zero.
// The first two corners of a triangle are accepted without stalling. The
// closing corner goes into a two-entry triangle queue; the back end pops a
// triangle, forms the UV determinant from two products, then for each of
// the six terms forms two products and runs a division on a single
// bit-serial divider, and finally loads the output register. A quotient
// that saturates skips the bit-serial steps; a degenerate triangle skips
// the terms and goes straight to the output. Corners keep flowing while
// the back end works, until the queue is full. A stalled master holds its
// beat; the back end finishes the next triangle and waits for the output
// register to free.
// Reset clears the corner count, the queue and the output valid.
module triangle_tangent_basis #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic [143:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // index_a, index_b, index_c, tangent_x/y/z, bitangent_x/y/z
  output logic [239:0]  m_axis_tdata,
  // degenerate
  output logic          m_axis_tuser
);

  localparam logic [15:0] IdxMask =
    (INDEX_BITS >= 16) ? 16'hFFFF : 16'((33'd1 << INDEX_BITS) - 33'd1);

  logic          push, push_ready, pop, pop_valid;
  ttb_pkg::tri_t push_data, pop_data;
  logic [2:0][31:0] pos;
  logic [1:0][15:0] tex;

  assign pos = s_axis_tdata[111:16];
  assign tex = s_axis_tdata[143:112];

  ttb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .idx_i       (s_axis_tdata[15:0] & IdxMask),
    .pos_i       (pos),
    .tex_i       (tex),
    .push_o      (push),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  ttb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  ttb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_o      (pop),
    .pop_data_i (pop_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_degen_o(m_axis_tuser)
  );

  // Degenerate triangles carry zero vectors
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[239:48] == '0)
    else $error("degenerate result with nonzero vectors");

  // Never write the queue when full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> push_ready)
    else $error("triangle queue overflow");

  // Never read the queue when empty
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pop_valid)
    else $error("triangle queue underflow");

endmodule

// File: dv/tb_triangle_tangent_basis.sv
`timescale 1ns / 100ps

module tb_triangle_tangent_basis;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned DrainCycles = 600;

  typedef struct packed {
    logic degenerate;
    logic [15:0] idx_a, idx_b, idx_c;
    logic [31:0] tan_x, tan_y, tan_z, bit_x, bit_y, bit_z;
  } basis_t;

  typedef struct {
    logic [15:0] idx;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] tu, tv;
    logic chk;         // typed-in result below is valid
    basis_t want;
  } corner_row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [239:0] m_axis_tdata;
  logic m_axis_tuser;

  triangle_tangent_basis u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Predictor state: corners held for the open triangle
  int unsigned held_count;
  logic [15:0] held_idx[2];
  longint held_pos[6];
  longint held_tex[4];

  basis_t basis_q[$];
  basis_t typed_q[$];  // typed-in expectation, tracked alongside
  bit typed_has[$];
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct, recv_idle_pct;
  bit recv_hold;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got, exp);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
    err_count++;
  endtask

  // num * 2^12 / det, truncated toward zero, saturated to 32 bits
  function automatic logic [31:0] scaled_quotient(longint num, longint det);
    bit neg;
    longint unsigned n, d, q;
    neg = (num < 0) != (det < 0);
    n = (num < 0) ? -num : num;
    d = (det < 0) ? -det : det;
    q = (n * 4096) / d;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
    return 32'(q);
  endfunction

  // Advance the corner state; return 1 with the basis when a triangle closes
  function automatic bit predict_corner(input corner_row_t c, output basis_t b);
    longint p[3], dp1[3], dp2[3], du1, dv1, du2, dv2, det, tn, bn;
    p[0] = c.px; p[1] = c.py; p[2] = c.pz;
    b = '0;
    if (held_count < 2) begin
      held_idx[held_count] = c.idx;
      for (int k = 0; k < 3; k++) held_pos[held_count*3+k] = p[k];
      held_tex[held_count*2] = c.tu;
      held_tex[held_count*2+1] = c.tv;
      held_count++;
      return 1'b0;
    end
    held_count = 0;
    for (int k = 0; k < 3; k++) begin
      dp1[k] = held_pos[3+k] - held_pos[k];
      dp2[k] = p[k] - held_pos[k];
    end
    du1 = held_tex[2] - held_tex[0];
    dv1 = held_tex[3] - held_tex[1];
    du2 = longint'(c.tu) - held_tex[0];
    dv2 = longint'(c.tv) - held_tex[1];
    det = du1 * dv2 - dv1 * du2;
    b.idx_a = held_idx[0];
    b.idx_b = held_idx[1];
    b.idx_c = c.idx;
    if (det == 0) begin
      b.degenerate = 1'b1;
      return 1'b1;
    end
    tn = dp1[0]*dv2 - dp2[0]*dv1; b.tan_x = scaled_quotient(tn, det);
    tn = dp1[1]*dv2 - dp2[1]*dv1; b.tan_y = scaled_quotient(tn, det);
    tn = dp1[2]*dv2 - dp2[2]*dv1; b.tan_z = scaled_quotient(tn, det);
    bn = dp2[0]*du1 - dp1[0]*du2; b.bit_x = scaled_quotient(bn, det);
    bn = dp2[1]*du1 - dp1[1]*du2; b.bit_y = scaled_quotient(bn, det);
    bn = dp2[2]*du1 - dp1[2]*du2; b.bit_z = scaled_quotient(bn, det);
    return 1'b1;
  endfunction

  // Drive one corner beat from a falling edge and wait for its acceptance;
  // valid stays high for the next beat unless the sender idles
  task automatic send_corner(input corner_row_t c);
    basis_t b;
    while (($urandom % 100) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {c.tv, c.tu, c.pz, c.py, c.px, c.idx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_corner(c, b)) begin
      basis_q = {basis_q, b};
      typed_q = {typed_q, c.want};
      typed_has = {typed_has, c.chk};
    end
    @(negedge clk_i);
  endtask

  function automatic corner_row_t make_corner(logic [15:0] idx, int px, py, pz,
                                              shortint tu, tv);
    corner_row_t c;
    c.idx = idx; c.px = px; c.py = py; c.pz = pz; c.tu = tu; c.tv = tv;
    c.chk = 1'b0; c.want = '0;
    return c;
  endfunction

  function automatic corner_row_t rand_corner(bit narrow);
    corner_row_t c;
    c = make_corner(16'($urandom), $urandom, $urandom, $urandom,
                    16'($urandom), 16'($urandom));
    if (narrow) begin
      // Keep UV deltas small so quotients stay mostly in range
      c.tu = 16'($urandom_range(0, 255)) - 16'sd128;
      c.tv = 16'($urandom_range(0, 255)) - 16'sd128;
      c.px = $signed(32'($urandom_range(0, 32'h0003_ffff))) - 32'sh0002_0000;
    end
    return c;
  endfunction

  // Receiver: random stalls plus an optional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni || recv_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= (($urandom % 100) >= recv_idle_pct);
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    basis_t got, exp, typed;
    bit has;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.degenerate = m_axis_tuser;
      {got.bit_z, got.bit_y, got.bit_x, got.tan_z, got.tan_y, got.tan_x,
       got.idx_c, got.idx_b, got.idx_a} = m_axis_tdata;
      if (basis_q.size() == 0) begin
        report_mismatch("unexpected beat", got.idx_a, '0);
      end else begin
        exp = basis_q.pop_front();
        typed = typed_q.pop_front();
        has = typed_has.pop_front();
        if (has && typed != exp) report_mismatch("typed row vs predictor", 0, 0);
        if (got.idx_a != exp.idx_a) report_mismatch("index_a", got.idx_a, exp.idx_a);
        if (got.idx_b != exp.idx_b) report_mismatch("index_b", got.idx_b, exp.idx_b);
        if (got.idx_c != exp.idx_c) report_mismatch("index_c", got.idx_c, exp.idx_c);
        if (got.tan_x != exp.tan_x) report_mismatch("tangent_x", got.tan_x, exp.tan_x);
        if (got.tan_y != exp.tan_y) report_mismatch("tangent_y", got.tan_y, exp.tan_y);
        if (got.tan_z != exp.tan_z) report_mismatch("tangent_z", got.tan_z, exp.tan_z);
        if (got.bit_x != exp.bit_x) report_mismatch("bitangent_x", got.bit_x, exp.bit_x);
        if (got.bit_y != exp.bit_y) report_mismatch("bitangent_y", got.bit_y, exp.bit_y);
        if (got.bit_z != exp.bit_z) report_mismatch("bitangent_z", got.bit_z, exp.bit_z);
        if (got.degenerate != exp.degenerate)
          report_mismatch("degenerate", got.degenerate, exp.degenerate);
      end
    end
  end

  initial begin
    corner_row_t rows[$];
    corner_row_t c;
    basis_t w;
    int unsigned wait_cycles;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    recv_hold = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 54;
    held_count = 0;
    err_count = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero determinant with extreme indices
    rows = {rows, make_corner(16'h0000, 0, 0, 0, 0, 0)};
    rows = {rows, make_corner(16'hffff, 32'sh7fff_ffff, 0, 0, 0, 0)};
    c = make_corner(16'h1234, 0, 0, 0, 0, 0);
    w = '0; w.degenerate = 1'b1; w.idx_a = 16'h0000; w.idx_b = 16'hffff;
    w.idx_c = 16'h1234;
    c.chk = 1'b1; c.want = w;
    rows = {rows, c};
    // Unit UV basis: tangent = dP1, bitangent = dP2 (det = 2^24)
    rows = {rows, make_corner(16'd1, 0, 0, 0, 0, 0)};
    rows = {rows, make_corner(16'd2, 32'sh0001_0000, 0, 0, 16'sh1000, 0)};
    c = make_corner(16'd3, 0, 32'sh0002_0000, 0, 0, 16'sh1000);
    w = '0; w.idx_a = 16'd1; w.idx_b = 16'd2; w.idx_c = 16'd3;
    w.tan_x = 32'h0001_0000; w.bit_y = 32'h0002_0000;
    c.chk = 1'b1; c.want = w;
    rows = {rows, c};
    // Positive saturation: huge dP over the smallest det
    rows = {rows, make_corner(16'd4, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0)};
    rows = {rows, make_corner(16'd5, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 16'sd1, 0)};
    c = make_corner(16'd6, 0, 0, 0, 0, 16'sd1);
    w = '0; w.idx_a = 16'd4; w.idx_b = 16'd5; w.idx_c = 16'd6;
    w.tan_x = 32'h7fff_ffff; w.tan_y = 32'h7fff_ffff;
    w.bit_x = 32'h7fff_ffff; w.bit_y = 32'h7fff_ffff;
    c.chk = 1'b1; c.want = w;
    rows = {rows, c};
    // Negative saturation and extreme UV corners
    rows = {rows, make_corner(16'd7, 32'sh7fff_ffff, 0, 32'sh7fff_ffff, 0, 0)};
    rows = {rows, make_corner(16'd8, 32'sh8000_0000, 0, 32'sh8000_0000, 16'sd1, 0)};
    c = make_corner(16'd9, 0, 0, 0, 0, 16'sd1);
    w = '0; w.idx_a = 16'd7; w.idx_b = 16'd8; w.idx_c = 16'd9;
    w.tan_x = 32'h8000_0000; w.tan_z = 32'h8000_0000;
    w.bit_x = 32'h8000_0000; w.bit_z = 32'h8000_0000;
    c.chk = 1'b1; c.want = w;
    rows = {rows, c};
    rows = {rows, make_corner(16'haaaa, 32'sh8000_0000, 32'sh7fff_ffff, -1,
                              16'sh8000, 16'sh7fff)};
    rows = {rows, make_corner(16'h5555, 32'sh7fff_ffff, 32'sh8000_0000, 1,
                              16'sh7fff, 16'sh8000)};
    rows = {rows, make_corner(16'h8001, -12345, 67890, 32'sh4000_0000,
                              16'sh8000, 16'sh8000)};
    foreach (rows[i]) begin
      send_corner(rows[i]);
    end

    // Random corners, idle profile changes by thirds
    for (int n = 0; n < 1935; n++) begin
      if (n == 645) begin send_idle_pct = 54; recv_idle_pct = 16; end
      if (n == 1290) begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (n == 300 || n == 1500) begin
        // Long receiver hold-off while corners keep coming
        fork
          begin
            recv_hold = 1'b1;
            repeat (3000) @(posedge clk_i);
            recv_hold = 1'b0;
          end
        join_none
      end
      if (n == 900) begin
        // Pause until every expected result is in (triangle boundary)
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (basis_q.size() != 0);
      end
      send_corner(rand_corner(($urandom % 4) != 0));
    end
    s_axis_tvalid <= 1'b0;

    wait_cycles = 0;
    while (basis_q.size() != 0 && wait_cycles < 200_000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && basis_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: triangle_tangent_basis.f
design/ttb_pkg.sv
design/ttb_front.sv
design/ttb_fifo.sv
design/ttb_div.sv
design/ttb_back.sv
design/triangle_tangent_basis.sv
dv/tb_triangle_tangent_basis.sv
